### rtl/cursor_sequence_list_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cursor sequence list
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CURSOR_SEQUENCE_LIST_TOP_DEFINES_SVH
`define CURSOR_SEQUENCE_LIST_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define CSL_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cursor sequence list check failed");

// A condition that must hold in the cycle after a trigger.
`define CSL_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("cursor sequence list sequence check failed");

`endif

### rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Sizes, command and status codes and beat types of the cursor sequence list.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int DEPTH       = 64;
  localparam int WORD_BITS   = 32;
  localparam int COUNT_BITS  = 7;
  localparam int ADDR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;

  localparam logic [KIND_BITS-1:0] KIND_REWIND  = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_ADVANCE = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_INSERT  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_ATTACH  = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE  = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_QUERY   = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NO_CURRENT = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL       = 2'd2;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [WORD_BITS-1:0] entry_value;
  } csl_in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  item_count;
    logic                   has_current;
    logic [WORD_BITS-1:0]   current_value;
  } csl_out_t;

endpackage

### rtl/cursor_sequence_list_top.sv
// ----------------------------------------------------------------------------
// cursor_sequence_list_top
// A command that reads the current item runs IDLE, READ, RESP; one that writes
// a new word runs IDLE, PUT, RESP; one that does neither runs IDLE, RESP.
// Insert, attach and remove that move items pass through SHIFT first, one item
// per step, then PUT for insert and attach. One command is in flight; the next
// input beat is taken after the result register loads, later if it is stalled.
// Reset clears count, cursor and the control; the item memory keeps its data.
// ----------------------------------------------------------------------------
`include "cursor_sequence_list_top_defines.svh"

module cursor_sequence_list_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  csl_pkg::csl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output csl_pkg::csl_out_t out_data
);
  import csl_pkg::*;

  // Sequencer states. A command is decoded in IDLE; SHIFT moves items one
  // place per cycle through the memory; READ fetches the current item;
  // PUT writes a newly placed word; RESP waits for the output register.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam int CW = COUNT_BITS;
  localparam int AW = ADDR_BITS;

  // Item memory: one write and one registered read per cycle.
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;
  logic [AW-1:0]        mem_raddr;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_we;

  logic [2:0]             state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          cursor_r, cursor_nxt;
  logic [AW-1:0]          rd_addr_r;
  logic [AW-1:0]          sh_end_r, sh_end_nxt;
  logic                   sh_up_r, sh_up_nxt;
  logic [WORD_BITS-1:0]   value_r, value_nxt;
  logic [WORD_BITS-1:0]   cur_val_r, cur_val_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  csl_out_t               out_data_r, out_data_nxt;

  logic          has_item;
  logic          is_full;
  logic [CW-1:0] pos;
  logic [CW-1:0] cursor_inc;

  assign has_item   = cursor_r < count_r;
  assign is_full    = count_r == CW'(DEPTH);
  assign cursor_inc = cursor_r + CW'(1);

  // The new word lands before the cursor for insert (front when there is no
  // current item) and after it for attach (end when there is none).
  always_comb begin
    if (in_data.kind == KIND_INSERT) begin
      pos = has_item ? cursor_r : '0;
    end else begin
      pos = has_item ? cursor_inc : count_r;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    sh_end_nxt    = sh_end_r;
    sh_up_nxt     = sh_up_r;
    value_nxt     = value_r;
    cur_val_nxt   = cur_val_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_raddr     = rd_addr_r;
    mem_we        = 1'b0;
    mem_waddr     = cursor_r[AW-1:0];
    mem_wdata     = value_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          value_nxt  = in_data.entry_value;
          unique case (in_data.kind) inside
            KIND_REWIND: begin
              cursor_nxt = '0;
              mem_raddr  = '0;
              state_nxt  = (count_r != '0) ? S_READ : S_RESP;
            end
            KIND_ADVANCE: begin
              if (has_item) begin
                cursor_nxt = cursor_inc;
                if (cursor_inc < count_r) begin
                  mem_raddr = cursor_inc[AW-1:0];
                  state_nxt = S_READ;
                end else begin
                  state_nxt = S_RESP;
                end
              end else begin
                status_nxt = ST_NO_CURRENT;
                state_nxt  = S_RESP;
              end
            end
            KIND_INSERT, KIND_ATTACH: begin
              if (is_full) begin
                // Nothing changes; the current item is still reported.
                status_nxt = ST_FULL;
                mem_raddr  = cursor_r[AW-1:0];
                state_nxt  = has_item ? S_READ : S_RESP;
              end else begin
                cursor_nxt = pos;
                count_nxt  = count_r + CW'(1);
                if (count_r > pos) begin
                  // Move items pos..count-1 up one place, top first.
                  mem_raddr  = AW'(count_r - CW'(1));
                  sh_end_nxt = pos[AW-1:0];
                  sh_up_nxt  = 1'b1;
                  state_nxt  = S_SHIFT;
                end else begin
                  state_nxt = S_PUT;
                end
              end
            end
            KIND_REMOVE: begin
              if (!has_item) begin
                status_nxt = ST_NO_CURRENT;
                state_nxt  = S_RESP;
              end else begin
                count_nxt = count_r - CW'(1);
                if (cursor_inc < count_r) begin
                  // Move items cursor+1..count-1 down one place, bottom first.
                  mem_raddr  = cursor_inc[AW-1:0];
                  sh_end_nxt = AW'(count_r - CW'(1));
                  sh_up_nxt  = 1'b0;
                  state_nxt  = S_SHIFT;
                end else begin
                  state_nxt = S_RESP;
                end
              end
            end
            default: begin
              mem_raddr = cursor_r[AW-1:0];
              state_nxt = has_item ? S_READ : S_RESP;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // The word read last cycle lands one place up or down; reads run
        // ahead of writes, so no entry is read after it is overwritten.
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        mem_waddr = sh_up_r ? (rd_addr_r + AW'(1)) : (rd_addr_r - AW'(1));
        if (!sh_up_r && (CW'(rd_addr_r) == cursor_inc)) begin
          cur_val_nxt = rdata_r;
        end
        if (rd_addr_r == sh_end_r) begin
          state_nxt = sh_up_r ? S_PUT : S_RESP;
        end else begin
          mem_raddr = sh_up_r ? (rd_addr_r - AW'(1)) : (rd_addr_r + AW'(1));
        end
      end
      S_READ: begin
        cur_val_nxt = rdata_r;
        state_nxt   = S_RESP;
      end
      S_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = cursor_r[AW-1:0];
        mem_wdata   = value_r;
        cur_val_nxt = value_r;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = status_r;
          out_data_nxt.item_count    = count_r;
          out_data_nxt.has_current   = has_item;
          out_data_nxt.current_value = has_item ? cur_val_r : '0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= mem_raddr;
    sh_end_r   <= sh_end_nxt;
    sh_up_r    <= sh_up_nxt;
    value_r    <= value_nxt;
    cur_val_r  <= cur_val_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The cursor never passes the count, and the count never passes the depth.
  `CSL_ASSERT_ALWAYS(a_cursor_in_range, cursor_r <= count_r)
  `CSL_ASSERT_ALWAYS(a_count_in_range, count_r <= CW'(DEPTH))
  // An accepted command always takes the sequencer out of the idle state.
  `CSL_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE)
  // A response that finds the output free is shown on the next cycle.
  `CSL_ASSERT_NEXT(a_resp_shown, (state_r == S_RESP) && (!out_valid_r || !out_stall),
                   out_valid_r && (state_r == S_IDLE))
  // Without a current item the reported value is zero.
  `CSL_ASSERT_ALWAYS(a_no_current_zero,
                     !out_valid_r || out_data_r.has_current || (out_data_r.current_value == '0))

endmodule
